FILE: hw/rtl/volume_table_block_mapper_defines.svh
// ----------------------------------------------------------------------------
// Volume table block mapper: assertion macros
// Shared concurrent assertion forms for the block's checkers.
// ----------------------------------------------------------------------------
`ifndef VOLUME_TABLE_BLOCK_MAPPER_DEFINES_SVH
`define VOLUME_TABLE_BLOCK_MAPPER_DEFINES_SVH

// Assertion on an explicit clock and active-low reset.
`define VTBM_ASSERT_ON(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("%m: check failed");

// Assertion on the block's own clock and reset.
`define VTBM_ASSERT(lbl, prop) `VTBM_ASSERT_ON(lbl, i_clk, i_rst_n, prop)

`endif

FILE: hw/rtl/vtbm_pkg.sv
// ----------------------------------------------------------------------------
// Volume table block mapper package
// Field widths, operation and status codes, and the transfer payload types.
// ----------------------------------------------------------------------------
`default_nettype none

package vtbm_pkg;

    localparam int unsigned IDX_W      = 3;
    localparam int unsigned BLK_W      = 24;
    localparam int unsigned CYL_W      = 16;
    localparam int unsigned SEC_W      = 16;
    localparam int unsigned LEN_W      = 24;
    localparam int unsigned SLOT_OUT_W = 3;
    localparam int unsigned MCYL_W     = 25;
    localparam int unsigned MSEC_W     = 16;
    localparam int unsigned TOTAL_W    = 4;
    localparam int unsigned SPC_W      = 16;
    localparam logic [SPC_W-1:0] SPC_RESET = 16'd16;
    localparam int unsigned DIV_STEPS  = MCYL_W;
    localparam int unsigned STEP_W     = $clog2(DIV_STEPS + 1);

    typedef enum logic [1:0] {
        OP_TRANSLATE = 2'd0,
        OP_ADD       = 2'd1,
        OP_DELETE    = 2'd2,
        OP_CLEAR     = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_VALID = 2'd2
    } t_status;

    typedef struct packed {
        t_op              operation;
        logic [IDX_W-1:0] volume_index;
        logic [BLK_W-1:0] block_number;
        logic [CYL_W-1:0] start_cylinder;
        logic [SEC_W-1:0] start_sector;
        logic [LEN_W-1:0] sector_count;
    } t_in_item;

    typedef struct packed {
        t_status               status;
        logic [SLOT_OUT_W-1:0] slot_added;
        logic [MCYL_W-1:0]     mapped_cylinder;
        logic [MSEC_W-1:0]     mapped_sector;
        logic [TOTAL_W-1:0]    volume_total;
    } t_out_item;

    typedef struct packed {
        logic [CYL_W-1:0] cylinder;
        logic [SEC_W-1:0] sector;
    } t_entry;

    typedef struct packed {
        logic              done;
        logic [MCYL_W-1:0] quotient;
        logic [SPC_W-1:0]  remainder;
    } t_div_rsp;

endpackage

`default_nettype wire

FILE: hw/rtl/vtbm_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module vtbm_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 8,
    localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: hw/rtl/vtbm_div.sv
// ----------------------------------------------------------------------------
// Sequential divider
// Restoring division, one quotient bit per cycle, with a done pulse.
// ----------------------------------------------------------------------------
`default_nettype none

module vtbm_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [vtbm_pkg::MCYL_W-1:0]   i_dividend,
    input  logic [vtbm_pkg::SPC_W-1:0]    i_divisor,
    output vtbm_pkg::t_div_rsp            o_rsp
);

    import vtbm_pkg::*;

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_step;
    logic [SPC_W-1:0]  r_rem;
    logic [MCYL_W-1:0] r_quo;
    logic [SPC_W-1:0]  r_div;

    logic [SPC_W:0]    trial;
    logic [SPC_W:0]    diff;
    logic              fits;
    logic [SPC_W-1:0]  n_rem;
    logic [MCYL_W-1:0] n_quo;

    always_comb begin
        trial = {r_rem, r_quo[MCYL_W-1]};
        diff  = trial - {1'b0, r_div};
        fits  = (trial >= {1'b0, r_div});
        n_rem = fits ? diff[SPC_W-1:0] : trial[SPC_W-1:0];
        n_quo = {r_quo[MCYL_W-2:0], fits};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
                r_rem  <= '0;
                r_quo  <= i_dividend;
                r_div  <= i_divisor;
            end else if (r_busy) begin
                r_rem  <= n_rem;
                r_quo  <= n_quo;
                r_step <= r_step + STEP_W'(1);
                if (r_step == STEP_W'(DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done      = r_done;
    assign o_rsp.quotient  = r_quo;
    assign o_rsp.remainder = r_rem;

endmodule

`default_nettype wire

FILE: hw/rtl/volume_table_block_mapper.sv
// ----------------------------------------------------------------------------
// Volume table block mapper
// Table of disk volumes with add, delete, clear and block translation.
// ----------------------------------------------------------------------------
// Commands arrive on the input channel (i_in_valid, o_in_stall) and each
// command gives exactly one result on the output channel (o_out_valid,
// i_out_stall). A transfer happens at a clock edge with valid high and
// stall low. The sectors per cylinder register is written through
// i_cfg_wr_en and i_cfg_wr_data; the user must do so only while no command
// is in flight, which the block does not enforce. Zero acts as one.
// Delete and clear go straight to the result; add scans the slots in order
// from slot 0 to the first free one or the last slot; translate reads the
// entry RAM, then runs the 25-step restoring divider. One command is in
// flight at a time; the next one can be taken in the cycle after the result
// is registered, so a stalled receiver holds one result while the next
// command runs. Volume entries live in a RAM with registered read data;
// the valid marks are flip-flops. Reset empties the table at once and sets
// 16 sectors per cylinder. A stalled result holds its payload until it is
// taken.
// ----------------------------------------------------------------------------
`default_nettype none

module volume_table_block_mapper #(
    parameter int unsigned TABLE_SLOTS = 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  vtbm_pkg::t_in_item          i_in_data,
    output logic                        o_in_stall,
    output logic                        o_out_valid,
    output vtbm_pkg::t_out_item         o_out_data,
    input  logic                        i_out_stall,
    input  logic                        i_cfg_wr_en,
    input  logic [vtbm_pkg::SPC_W-1:0]  i_cfg_wr_data
);

    import vtbm_pkg::*;

    localparam int unsigned SLOT_W    = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam int unsigned COUNT_W   = $clog2(TABLE_SLOTS + 1);
    localparam int unsigned LAST_SLOT = TABLE_SLOTS - 1;

    typedef logic [SLOT_W-1:0] t_slot;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_READ = 5'b00010,
        S_SCAN = 5'b00100,
        S_DIV  = 5'b01000,
        S_DONE = 5'b10000
    } t_state;

    t_state                 r_state, n_state;
    logic [SPC_W-1:0]       r_spc;
    logic [TABLE_SLOTS-1:0] r_valid, n_valid;
    logic [COUNT_W-1:0]     r_count, n_count;
    t_slot                  r_ptr, n_ptr;
    t_in_item               r_req;
    logic                   r_hit;
    logic [CYL_W-1:0]       r_base_c;
    t_out_item              r_res, n_res;
    logic                   r_out_valid, n_out_valid;
    t_out_item              r_out_data, n_out_data;

    logic                   in_accept;
    logic                   out_free;
    logic                   idx_in_range;
    t_slot                  idx_slot;
    logic                   idx_hit;
    logic                   ram_we;
    t_entry                 ram_wdata;
    t_entry                 ram_rdata;
    logic                   div_start;
    logic [MCYL_W-1:0]      lin;
    logic [SPC_W-1:0]       spc_eff;
    t_div_rsp               div_rsp;

    assign o_in_stall   = (r_state != S_IDLE);
    assign in_accept    = i_in_valid && !o_in_stall;
    assign out_free     = !r_out_valid || !i_out_stall;
    assign idx_in_range = (32'(i_in_data.volume_index) < TABLE_SLOTS);
    assign idx_slot     = t_slot'(i_in_data.volume_index);
    assign idx_hit      = idx_in_range && r_valid[idx_slot];

    assign ram_we    = (r_state == S_SCAN) && !r_valid[r_ptr];
    assign ram_wdata = '{cylinder: r_req.start_cylinder, sector: r_req.start_sector};

    vtbm_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (TABLE_SLOTS)
    ) u_entry_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_ptr),
        .i_wdata (ram_wdata),
        .i_raddr (idx_slot),
        .o_rdata (ram_rdata)
    );

    assign spc_eff   = (r_spc == '0) ? SPC_W'(1) : r_spc;
    assign lin       = MCYL_W'(r_hit ? ram_rdata.sector : '0)
                     + MCYL_W'(r_req.block_number);
    assign div_start = (r_state == S_READ);

    vtbm_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (lin),
        .i_divisor  (spc_eff),
        .o_rsp      (div_rsp)
    );

    always_comb begin
        n_state     = r_state;
        n_valid     = r_valid;
        n_count     = r_count;
        n_ptr       = r_ptr;
        n_res       = r_res;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_data  = r_out_data;
        unique case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_res              = '0;
                    n_res.status       = ST_OK;
                    n_res.volume_total = TOTAL_W'(r_count);
                    unique case (i_in_data.operation)
                        OP_TRANSLATE: begin
                            n_state = S_READ;
                        end
                        OP_ADD: begin
                            n_ptr   = '0;
                            n_state = S_SCAN;
                        end
                        OP_DELETE: begin
                            if (idx_hit) begin
                                n_valid[idx_slot]  = 1'b0;
                                n_count            = r_count - COUNT_W'(1);
                                n_res.volume_total = TOTAL_W'(r_count - COUNT_W'(1));
                            end else begin
                                n_res.status = ST_NOT_VALID;
                            end
                            n_state = S_DONE;
                        end
                        OP_CLEAR: begin
                            n_valid            = '0;
                            n_count            = '0;
                            n_res.volume_total = '0;
                            n_state            = S_DONE;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_READ: begin
                n_state = S_DIV;
            end
            S_DIV: begin
                if (div_rsp.done) begin
                    n_res.mapped_cylinder = MCYL_W'(r_base_c) + div_rsp.quotient;
                    n_res.mapped_sector   = div_rsp.remainder;
                    n_state               = S_DONE;
                end
            end
            S_SCAN: begin
                if (!r_valid[r_ptr]) begin
                    n_valid[r_ptr]     = 1'b1;
                    n_count            = r_count + COUNT_W'(1);
                    n_res.slot_added   = SLOT_OUT_W'(r_ptr);
                    n_res.volume_total = TOTAL_W'(r_count + COUNT_W'(1));
                    n_state            = S_DONE;
                end else if (r_ptr == t_slot'(LAST_SLOT)) begin
                    n_res.status = ST_FULL;
                    n_state      = S_DONE;
                end else begin
                    n_ptr = r_ptr + t_slot'(1);
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_data  = r_res;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_spc       <= SPC_RESET;
            r_valid     <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_valid     <= n_valid;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            if (i_cfg_wr_en) begin
                r_spc <= i_cfg_wr_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr      <= n_ptr;
        r_res      <= n_res;
        r_out_data <= n_out_data;
        if (in_accept) begin
            r_req <= i_in_data;
            r_hit <= idx_hit;
        end
        if (r_state == S_READ) begin
            r_base_c <= r_hit ? ram_rdata.cylinder : '0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

`default_nettype wire

FILE: hw/rtl/vtbm_checker.sv
// ----------------------------------------------------------------------------
// Volume table block mapper checker
// Port-level assertions, attached to the top level by a bind statement.
// ----------------------------------------------------------------------------
`default_nettype none

`include "volume_table_block_mapper_defines.svh"

module vtbm_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input vtbm_pkg::t_in_item  i_in_data,
    input logic                o_in_stall,
    input logic                o_out_valid,
    input vtbm_pkg::t_out_item o_out_data,
    input logic                i_out_stall
);

    import vtbm_pkg::*;

    logic in_seen;

    assign in_seen = i_in_valid && (i_in_data.volume_index == i_in_data.volume_index);

    `VTBM_ASSERT(a_accept_then_busy, in_seen && !o_in_stall |=> o_in_stall)
    `VTBM_ASSERT(a_stalled_result_holds, o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
    `VTBM_ASSERT(a_full_has_no_mapping, o_out_valid && o_out_data.status == ST_FULL |-> o_out_data.slot_added == '0 && o_out_data.mapped_cylinder == '0 && o_out_data.mapped_sector == '0)
    `VTBM_ASSERT(a_result_after_busy, $rose(o_out_valid) |-> $past(o_in_stall))

endmodule

bind volume_table_block_mapper vtbm_checker u_vtbm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .i_in_data   (i_in_data),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .o_out_data  (o_out_data),
    .i_out_stall (i_out_stall)
);

`default_nettype wire

FILE: tb/tb_volume_table_block_mapper.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Volume table block mapper testbench
// Runs a table of directed commands at the reset geometry, then random
// command streams under six sector-per-cylinder settings. Results are
// checked against typed rows or a cycle-free volume table model in the bench.
// ----------------------------------------------------------------------------

module tb_volume_table_block_mapper;
    import vtbm_pkg::*;

    localparam int unsigned SLOTS           = 8;
    localparam int unsigned PHASES          = 6;
    localparam int unsigned ITEMS_PER_PHASE = 108;
    localparam int unsigned REPORT_LIMIT    = 10;
    localparam int unsigned SETTLE_CYCLES   = 40;
    localparam int unsigned TIMEOUT_NS      = 5_000_000;

    typedef struct {
        t_in_item  cmd;
        bit        typed;
        t_out_item result;
    } t_dir_row;

    logic             i_clk         = 1'b0;
    logic             i_rst_n       = 1'b0;
    logic             i_in_valid    = 1'b0;
    t_in_item         i_in_data     = '0;
    logic             o_in_stall;
    logic             o_out_valid;
    t_out_item        o_out_data;
    logic             i_out_stall   = 1'b0;
    logic             i_cfg_wr_en   = 1'b0;
    logic [SPC_W-1:0] i_cfg_wr_data = '0;

    bit               vol_valid    [SLOTS];
    logic [CYL_W-1:0] vol_cylinder [SLOTS];
    logic [SEC_W-1:0] vol_sector   [SLOTS];
    logic [LEN_W-1:0] vol_length   [SLOTS];
    int unsigned      vol_count;
    logic [SPC_W-1:0] geometry;

    t_out_item   pending_results[$];
    int unsigned send_idle_pct;
    int unsigned stall_pct;
    int unsigned mismatches;
    int unsigned results_checked;
    int unsigned commands_sent;
    int unsigned ops_sent[4];
    int unsigned full_seen;
    int unsigned not_valid_seen;

    volume_table_block_mapper #(
        .TABLE_SLOTS(SLOTS)
    ) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_in_data     (i_in_data),
        .o_in_stall    (o_in_stall),
        .o_out_valid   (o_out_valid),
        .o_out_data    (o_out_data),
        .i_out_stall   (i_out_stall),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("Timeout with %0d results outstanding.", pending_results.size());
        $display("volume_table_block_mapper test failed");
        $finish;
    end

    function automatic void clear_volume_model();
        foreach (vol_valid[i]) begin
            vol_valid[i]    = 1'b0;
            vol_cylinder[i] = '0;
            vol_sector[i]   = '0;
            vol_length[i]   = '0;
        end
        vol_count = 0;
    endfunction

    function automatic t_out_item map_command(input t_in_item cmd);
        t_out_item         res;
        logic [MCYL_W-1:0] linear;
        logic [SPC_W:0]    divisor;
        int unsigned       slot;
        res        = '0;
        res.status = ST_OK;
        case (cmd.operation)
            OP_TRANSLATE: begin
                divisor = (geometry == '0) ? 17'd1 : {1'b0, geometry};
                linear  = vol_sector[cmd.volume_index] + cmd.block_number;
                res.mapped_cylinder = vol_cylinder[cmd.volume_index] + linear / divisor;
                res.mapped_sector   = MSEC_W'(linear % divisor);
            end
            OP_ADD: begin
                slot = 0;
                while (slot < SLOTS && vol_valid[slot]) slot++;
                if (slot == SLOTS) begin
                    res.status = ST_FULL;
                end else begin
                    vol_valid[slot]    = 1'b1;
                    vol_cylinder[slot] = cmd.start_cylinder;
                    vol_sector[slot]   = cmd.start_sector;
                    vol_length[slot]   = cmd.sector_count;
                    vol_count++;
                    res.slot_added = SLOT_OUT_W'(slot);
                end
            end
            OP_DELETE: begin
                if (vol_valid[cmd.volume_index]) begin
                    vol_valid[cmd.volume_index]    = 1'b0;
                    vol_cylinder[cmd.volume_index] = '0;
                    vol_sector[cmd.volume_index]   = '0;
                    vol_length[cmd.volume_index]   = '0;
                    if (vol_count > 0) vol_count--;
                end else begin
                    res.status = ST_NOT_VALID;
                end
            end
            default: begin
                clear_volume_model();
            end
        endcase
        res.volume_total = TOTAL_W'(vol_count);
        return res;
    endfunction

    function automatic t_in_item make_cmd(input t_op op, input int unsigned idx,
                                          input int unsigned blk, input int unsigned cyl,
                                          input int unsigned sec, input int unsigned cnt);
        t_in_item cmd;
        cmd.operation      = op;
        cmd.volume_index   = IDX_W'(idx);
        cmd.block_number   = BLK_W'(blk);
        cmd.start_cylinder = CYL_W'(cyl);
        cmd.start_sector   = SEC_W'(sec);
        cmd.sector_count   = LEN_W'(cnt);
        return cmd;
    endfunction

    function automatic t_out_item make_res(input t_status st, input int unsigned slot,
                                           input int unsigned mcyl, input int unsigned msec,
                                           input int unsigned total);
        t_out_item res;
        res.status          = st;
        res.slot_added      = SLOT_OUT_W'(slot);
        res.mapped_cylinder = MCYL_W'(mcyl);
        res.mapped_sector   = MSEC_W'(msec);
        res.volume_total    = TOTAL_W'(total);
        return res;
    endfunction

    function automatic t_in_item random_command();
        t_in_item    cmd;
        int unsigned pick;
        int unsigned live_slots[$];
        cmd.volume_index   = IDX_W'($urandom);
        cmd.block_number   = BLK_W'($urandom);
        cmd.start_cylinder = CYL_W'($urandom);
        cmd.start_sector   = SEC_W'($urandom);
        cmd.sector_count   = LEN_W'($urandom);
        if ($urandom_range(9) == 0) cmd.block_number = $urandom_range(1) ? '1 : '0;
        if ($urandom_range(9) == 0) cmd.start_sector = $urandom_range(1) ? '1 : '0;
        if ($urandom_range(9) == 0) cmd.start_cylinder = $urandom_range(1) ? '1 : '0;
        foreach (vol_valid[i]) begin
            if (vol_valid[i]) live_slots.push_back(i);
        end
        pick = $urandom_range(99);
        if (pick < 43) begin
            cmd.operation = OP_TRANSLATE;
        end else if (pick < 80) begin
            cmd.operation = OP_ADD;
        end else if (pick < 97) begin
            cmd.operation = OP_DELETE;
        end else begin
            cmd.operation = OP_CLEAR;
        end
        if (cmd.operation inside {OP_TRANSLATE, OP_DELETE} && live_slots.size() != 0 &&
            $urandom_range(3) != 0) begin
            cmd.volume_index = IDX_W'(live_slots[$urandom_range(live_slots.size() - 1)]);
        end
        return cmd;
    endfunction

    function automatic void report_failure(input string what);
        mismatches++;
        if (mismatches <= REPORT_LIMIT) $display("ERROR at %0t ns: %s", $time, what);
    endfunction

    function automatic void check_result(input t_out_item act);
        t_out_item exp;
        if (pending_results.size() == 0) begin
            report_failure($sformatf("result with nothing expected: %p", act));
            return;
        end
        exp = pending_results.pop_front();
        results_checked++;
        if (act.status !== exp.status || act.slot_added !== exp.slot_added ||
            act.mapped_cylinder !== exp.mapped_cylinder ||
            act.mapped_sector !== exp.mapped_sector ||
            act.volume_total !== exp.volume_total) begin
            report_failure($sformatf(
                "result %0d: expected st %0d slot %0d cyl %0d sec %0d total %0d, got st %0d slot %0d cyl %0d sec %0d total %0d",
                results_checked, exp.status, exp.slot_added, exp.mapped_cylinder,
                exp.mapped_sector, exp.volume_total, act.status, act.slot_added,
                act.mapped_cylinder, act.mapped_sector, act.volume_total));
        end
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) check_result(o_out_data);
    end

    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < stall_pct);
    end

    task automatic push_command(input t_in_item cmd, input bit typed,
                                input t_out_item typed_res);
        t_out_item predicted;
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= cmd;
        @(posedge i_clk);
        while (o_in_stall !== 1'b0) @(posedge i_clk);
        predicted = map_command(cmd);
        if (predicted.status == ST_FULL) full_seen++;
        if (predicted.status == ST_NOT_VALID) not_valid_seen++;
        pending_results.push_back(typed ? typed_res : predicted);
        commands_sent++;
        ops_sent[cmd.operation]++;
    endtask

    task automatic wait_for_results();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_geometry(input logic [SPC_W-1:0] value);
        wait_for_results();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        geometry = value;
    endtask

    initial begin : stimulus
        t_dir_row         directed_rows[$];
        logic [SPC_W-1:0] phase_geometry[PHASES];
        clear_volume_model();
        geometry      = SPC_RESET;
        send_idle_pct = 25;
        stall_pct     = 73;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        directed_rows.push_back('{make_cmd(OP_TRANSLATE, 0, 0, 0, 0, 0), 1'b1,
                                  make_res(ST_OK, 0, 0, 0, 0)});
        directed_rows.push_back('{make_cmd(OP_TRANSLATE, 7, 24'hFFFFFF, 0, 0, 0), 1'b1,
                                  make_res(ST_OK, 0, 1048575, 15, 0)});
        directed_rows.push_back('{make_cmd(OP_DELETE, 3, 0, 0, 0, 0), 1'b1,
                                  make_res(ST_NOT_VALID, 0, 0, 0, 0)});
        directed_rows.push_back('{make_cmd(OP_ADD, 0, 0, 16'hFFFF, 16'hFFFF, 24'hFFFFFF),
                                  1'b1, make_res(ST_OK, 0, 0, 0, 1)});
        directed_rows.push_back('{make_cmd(OP_TRANSLATE, 0, 24'hFFFFFF, 0, 0, 0), 1'b0,
                                  make_res(ST_OK, 0, 0, 0, 0)});
        for (int i = 1; i < SLOTS; i++) begin
            directed_rows.push_back('{make_cmd(OP_ADD, 0, 0, i * 1000, i * 37, i * 4096),
                                      1'b1, make_res(ST_OK, i, 0, 0, i + 1)});
        end
        directed_rows.push_back('{make_cmd(OP_ADD, 5, 0, 1, 2, 3), 1'b1,
                                  make_res(ST_FULL, 0, 0, 0, 8)});
        directed_rows.push_back('{make_cmd(OP_TRANSLATE, 5, 12345, 0, 0, 0), 1'b0,
                                  make_res(ST_OK, 0, 0, 0, 0)});
        directed_rows.push_back('{make_cmd(OP_DELETE, 2, 0, 0, 0, 0), 1'b1,
                                  make_res(ST_OK, 0, 0, 0, 7)});
        directed_rows.push_back('{make_cmd(OP_DELETE, 2, 0, 0, 0, 0), 1'b1,
                                  make_res(ST_NOT_VALID, 0, 0, 0, 7)});
        directed_rows.push_back('{make_cmd(OP_ADD, 0, 0, 0, 0, 0), 1'b1,
                                  make_res(ST_OK, 2, 0, 0, 8)});
        directed_rows.push_back('{make_cmd(OP_TRANSLATE, 2, 0, 0, 0, 0), 1'b1,
                                  make_res(ST_OK, 0, 0, 0, 8)});
        directed_rows.push_back('{make_cmd(OP_TRANSLATE, 7, 24'h800000, 0, 0, 0), 1'b0,
                                  make_res(ST_OK, 0, 0, 0, 0)});
        directed_rows.push_back('{make_cmd(OP_CLEAR, 7, 24'hFFFFFF, 16'hFFFF, 16'hFFFF,
                                           24'hFFFFFF), 1'b1, make_res(ST_OK, 0, 0, 0, 0)});
        directed_rows.push_back('{make_cmd(OP_TRANSLATE, 6, 33, 0, 0, 0), 1'b1,
                                  make_res(ST_OK, 0, 2, 1, 0)});
        directed_rows.push_back('{make_cmd(OP_DELETE, 0, 0, 0, 0, 0), 1'b1,
                                  make_res(ST_NOT_VALID, 0, 0, 0, 0)});
        foreach (directed_rows[i]) begin
            push_command(directed_rows[i].cmd, directed_rows[i].typed,
                         directed_rows[i].result);
        end

        phase_geometry[0] = '0;
        phase_geometry[1] = 16'd1;
        phase_geometry[2] = 16'hFFFF;
        phase_geometry[3] = SPC_W'($urandom_range(2, 65534));
        phase_geometry[4] = 16'd3;
        phase_geometry[5] = SPC_W'($urandom_range(1, 40));
        for (int p = 0; p < PHASES; p++) begin
            send_idle_pct = (p < 2) ? 25 : (p < 4) ? 73 : 0;
            stall_pct     = (p < 2) ? 73 : (p < 4) ? 25 : 0;
            write_geometry(phase_geometry[p]);
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if ($urandom_range(59) == 0) wait_for_results();
                push_command(random_command(), 1'b0, '0);
            end
        end

        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        while (pending_results.size() != 0) begin
            report_failure($sformatf("expected result never arrived: %p",
                                     pending_results.pop_front()));
        end
        $display("Covered %0d commands (%0d translate, %0d add, %0d delete, %0d clear) and %0d results.",
                 commands_sent, ops_sent[OP_TRANSLATE], ops_sent[OP_ADD],
                 ops_sent[OP_DELETE], ops_sent[OP_CLEAR], results_checked);
        $display("Saw %0d adds on a full table and %0d deletes of free slots over %0d geometries.",
                 full_seen, not_valid_seen, PHASES + 1);
        if (mismatches == 0) begin
            $display("volume_table_block_mapper test passed");
        end else begin
            $display("%0d failures.", mismatches);
            $display("volume_table_block_mapper test failed");
        end
        $finish;
    end

endmodule
